// ===== rtl/rmlh_pkg.sv =====
// package for the ray march light hit block: payload types, register indexes, sine table
package rmlh_pkg;

    // default sizes
    localparam int MAX_STEPS_DEF = 850;
    localparam int ANGLES_DEF    = 360;
    localparam int OBSTACLES_DEF = 6;
    localparam int BORDER_DEF    = 5;
    localparam int FRAC_BITS_DEF = 14;

    // fixed field widths
    localparam int COORD_W   = 10;
    localparam int ANGLE_W   = 9;
    localparam int OUT_W     = 16;
    localparam int STEP_W    = 10;
    localparam int OBST_W    = 41;
    localparam int OBST_NUM  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int TAB_W     = 15;

    // reset values of the screen size registers
    localparam logic [COORD_W-1:0] SCREEN_W_RST = 10'd850;
    localparam logic [COORD_W-1:0] SCREEN_H_RST = 10'd450;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OBST_A   = 3'd0,
        CFG_OBST_B   = 3'd1,
        CFG_OBST_C   = 3'd2,
        CFG_OBST_D   = 3'd3,
        CFG_OBST_E   = 3'd4,
        CFG_OBST_F   = 3'd5,
        CFG_SCREEN_W = 3'd6,
        CFG_SCREEN_H = 3'd7
    } t_cfg_idx;

    // input beat
    typedef struct packed {
        logic [COORD_W-1:0] light_x;
        logic [COORD_W-1:0] light_y;
        logic [ANGLE_W-1:0] ray_angle;
    } t_ray_in;

    // result beat
    typedef struct packed {
        logic [OUT_W-1:0]  hit_x;
        logic [OUT_W-1:0]  hit_y;
        logic              blocked;
        logic [STEP_W-1:0] step_count;
    } t_ray_out;

    // quarter wave sine, q1.14, 0..90 degrees
    function automatic logic [TAB_W-1:0] sin_q14(input logic [6:0] k);
        logic [TAB_W-1:0] v;
        begin
            unique case (k)
                7'd0:  v = 15'd0;     7'd1:  v = 15'd286;   7'd2:  v = 15'd572;
                7'd3:  v = 15'd857;   7'd4:  v = 15'd1143;  7'd5:  v = 15'd1428;
                7'd6:  v = 15'd1713;  7'd7:  v = 15'd1997;  7'd8:  v = 15'd2280;
                7'd9:  v = 15'd2563;  7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
                7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
                7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
                7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
                7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
                7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
                7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
                7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
                7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
                7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
                7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
                7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
                7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
                7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
                7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
                7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
                7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
                7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
                7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
                7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
                7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
                7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
                7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
                7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
                7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
                7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
                7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
                7'd90: v = 15'd16384;
                default: v = 15'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/ray_march_light_hit.sv =====
// top level: single ray march from a light point against obstacle and border rectangles
//
//  channel   | ports                        | handshake
//  ----------+------------------------------+------------------------------------
//  ray in    | i_start, i_ray               | taken when i_start && !o_busy
//  result    | o_done, o_hit                | one-cycle strobe, no back-pressure
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data | written on any edge with i_cfg_we
//
//  after the start beat is taken the sequencer reduces the angle modulo ANGLES by
//  repeated subtraction (none for angles below ANGLES), sets the direction, then tests
//  n march points (n in 1..MAX_STEPS), one per cycle by the shared adder and the parallel
//  rectangle compares, and then registers the result with the done strobe.
//  o_busy is high from the start beat until the done strobe, so the next start can be
//  taken at the edge that takes the result.
//  reset is synchronous, active low, and restores the screen size and clears obstacles.
//  the result is a single beat on o_done; the receiver cannot stall it.
module ray_march_light_hit
    import rmlh_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int ANGLES    = ANGLES_DEF,
    parameter int OBSTACLES = OBSTACLES_DEF,
    parameter int BORDER    = BORDER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_ray_in              i_ray,
    output logic                 o_busy,
    output logic                 o_done,
    output t_ray_out             o_hit,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [OBST_W-1:0]    i_cfg_data
);

    // derived widths
    localparam int CW   = FRAC_BITS + 12;   // signed point coordinate
    localparam int DW   = FRAC_BITS + 2;    // signed direction component
    localparam int PW   = 13;               // signed whole-pixel compare width
    localparam int SHL  = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
    localparam int SHR  = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
    localparam int HALF = (SHR > 0) ? (1 << (SHR - 1)) : 0;
    localparam int OSH  = FRAC_BITS - 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_DIR,
        S_MARCH,
        S_FIN
    } t_state;

    // configuration registers
    logic [OBST_W-1:0]  r_obst [OBST_NUM];
    logic [COORD_W-1:0] r_scr_w;
    logic [COORD_W-1:0] r_scr_h;

    // sequencer and datapath registers
    t_state               r_state;
    logic [ANGLE_W-1:0]   r_angle;
    logic [COORD_W-1:0]   r_lx;
    logic [COORD_W-1:0]   r_ly;
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic signed [CW-1:0] r_px;
    logic signed [CW-1:0] r_py;
    logic [STEP_W-1:0]    r_dist;
    logic [STEP_W-1:0]    r_steps;
    logic                 r_blocked;
    logic                 r_done;
    t_ray_out             r_hit;

    logic signed [DW-1:0] n_dx;
    logic signed [DW-1:0] n_dy;
    logic signed [CW-1:0] n_px;
    logic signed [CW-1:0] n_py;
    logic [ANGLE_W-1:0]   cos_angle;
    logic signed [PW-1:0] pix_x;
    logic signed [PW-1:0] pix_y;
    logic [OBST_NUM-1:0]  obst_hit;
    logic [3:0]           band_hit;
    logic                 any_hit;

    // rescale a table entry to the working fraction width, rounding half up
    function automatic logic [DW-2:0] scaled(input logic [TAB_W-1:0] v);
        logic [17:0] t;
        begin
            t = ((18'(v) << SHL) + 18'(HALF)) >> SHR;
            return t[DW-2:0];
        end
    endfunction

    // signed sine of an angle below 360 by quadrant symmetry
    function automatic logic signed [DW-1:0] sin_fixed(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] k;
        logic               neg;
        logic [DW-1:0]      mag;
        begin
            priority if (a <= 9'd90) begin
                k = a;
                neg = 1'b0;
            end else if (a <= 9'd180) begin
                k = 9'd180 - a;
                neg = 1'b0;
            end else if (a <= 9'd270) begin
                k = a - 9'd180;
                neg = 1'b1;
            end else begin
                k = 9'd360 - a;
                neg = 1'b1;
            end
            mag = {1'b0, scaled(sin_q14(k[6:0]))};
            return neg ? -$signed(mag) : $signed(mag);
        end
    endfunction

    // half-open rectangle test in whole pixels
    function automatic logic in_rect(
        input logic signed [PW-1:0] x,
        input logic signed [PW-1:0] y,
        input logic signed [PW-1:0] rx,
        input logic signed [PW-1:0] ry,
        input logic signed [PW-1:0] rw,
        input logic signed [PW-1:0] rh
    );
        return (x >= rx) && (x < rx + rw) && (y >= ry) && (y < ry + rh);
    endfunction

    // point to output units: negative gives zero, large values saturate
    function automatic logic [OUT_W-1:0] to_out(input logic signed [CW-1:0] v);
        logic [CW-1:0] sh;
        begin
            sh = $unsigned(v) >> OSH;
            priority if (v[CW-1]) return '0;
            else if (|sh[CW-1:OUT_W]) return '1;
            else return sh[OUT_W-1:0];
        end
    endfunction

    // direction lookup, cosine taken as the sine a quarter turn on
    always_comb begin
        cos_angle = (r_angle >= 9'd270) ? r_angle - 9'd270 : r_angle + 9'd90;
        n_dx = sin_fixed(r_angle);
        n_dy = -sin_fixed(cos_angle);
    end

    // shared step adder: first point from the light, then one unit per step
    always_comb begin
        if (r_state == S_DIR) begin
            n_px = $signed({2'b00, r_lx, {FRAC_BITS{1'b0}}}) + CW'(n_dx);
            n_py = $signed({2'b00, r_ly, {FRAC_BITS{1'b0}}}) + CW'(n_dy);
        end else begin
            n_px = r_px + CW'(r_dx);
            n_py = r_py + CW'(r_dy);
        end
    end

    // whole-pixel part of the current point, floor toward minus infinity
    assign pix_x = PW'($signed(r_px[CW-1:FRAC_BITS]));
    assign pix_y = PW'($signed(r_py[CW-1:FRAC_BITS]));

    // enabled obstacle rectangles, all tested at the same point
    genvar g;
    generate
        for (g = 0; g < OBST_NUM; g++) begin : g_obst
            if (g < OBSTACLES) begin : g_on
                assign obst_hit[g] = r_obst[g][40] && in_rect(pix_x, pix_y,
                    PW'(r_obst[g][39:30]), PW'(r_obst[g][29:20]),
                    PW'(r_obst[g][19:10]), PW'(r_obst[g][9:0]));
            end else begin : g_off
                assign obst_hit[g] = 1'b0;
            end
        end
    endgenerate

    // border band: top, bottom, left, right
    always_comb begin
        logic signed [PW-1:0] w;
        logic signed [PW-1:0] h;
        logic signed [PW-1:0] b;
        w = PW'(r_scr_w);
        h = PW'(r_scr_h);
        b = PW'(BORDER);
        band_hit[0] = in_rect(pix_x, pix_y, '0, '0, w, b);
        band_hit[1] = in_rect(pix_x, pix_y, '0, h - b, w, b);
        band_hit[2] = in_rect(pix_x, pix_y, '0, b, b, h - b - b);
        band_hit[3] = in_rect(pix_x, pix_y, w - b, b, b, h - b - b);
    end

    assign any_hit = (|obst_hit) || (|band_hit);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < OBST_NUM; k++) begin
                r_obst[k] <= '0;
            end
            r_scr_w <= SCREEN_W_RST;
            r_scr_h <= SCREEN_H_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_OBST_A:   r_obst[0] <= i_cfg_data;
                CFG_OBST_B:   r_obst[1] <= i_cfg_data;
                CFG_OBST_C:   r_obst[2] <= i_cfg_data;
                CFG_OBST_D:   r_obst[3] <= i_cfg_data;
                CFG_OBST_E:   r_obst[4] <= i_cfg_data;
                CFG_OBST_F:   r_obst[5] <= i_cfg_data;
                CFG_SCREEN_W: r_scr_w <= i_cfg_data[COORD_W-1:0];
                CFG_SCREEN_H: r_scr_h <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, datapath and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_lx    <= i_ray.light_x;
                        r_ly    <= i_ray.light_y;
                        r_angle <= i_ray.ray_angle;
                        r_state <= S_REDUCE;
                    end
                end
                // angle modulo ANGLES by repeated subtraction
                S_REDUCE: begin
                    if (r_angle >= ANGLE_W'(ANGLES)) begin
                        r_angle <= r_angle - ANGLE_W'(ANGLES);
                    end else begin
                        r_state <= S_DIR;
                    end
                end
                // direction and the point at distance one
                S_DIR: begin
                    r_dx    <= n_dx;
                    r_dy    <= n_dy;
                    r_px    <= n_px;
                    r_py    <= n_py;
                    r_dist  <= STEP_W'(1);
                    r_state <= S_MARCH;
                end
                // one point tested per cycle
                S_MARCH: begin
                    if (any_hit) begin
                        r_blocked <= 1'b1;
                        r_steps   <= r_dist - STEP_W'(1);
                        r_state   <= S_FIN;
                    end else begin
                        r_px   <= n_px;
                        r_py   <= n_py;
                        r_dist <= r_dist + STEP_W'(1);
                        if (r_dist == STEP_W'(MAX_STEPS)) begin
                            r_blocked <= 1'b0;
                            r_steps   <= STEP_W'(MAX_STEPS);
                            r_state   <= S_FIN;
                        end
                    end
                end
                // result beat
                S_FIN: begin
                    r_hit.hit_x      <= to_out(r_px);
                    r_hit.hit_y      <= to_out(r_py);
                    r_hit.blocked    <= r_blocked;
                    r_hit.step_count <= r_steps;
                    r_done           <= 1'b1;
                    r_state          <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_hit  = r_hit;

endmodule

// ===== tb/ray_march_light_hit_tb.sv =====
// testbench for ray_march_light_hit: random and directed rays checked against a local march model
`timescale 1ns / 1ps

module ray_march_light_hit_tb;
    import rmlh_pkg::*;

    localparam int     MARCH_MAX  = MAX_STEPS_DEF;
    localparam int     DEG_WRAP   = ANGLES_DEF;
    localparam int     RECT_NUM   = OBSTACLES_DEF;
    localparam int     BAND       = BORDER_DEF;
    localparam int     FRAC       = FRAC_BITS_DEF;
    localparam int     RAND_PHASES = 10;
    localparam int     RAYS_PER_PHASE = 70;
    localparam int     DRAIN_CYCLES = 1000;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    t_ray_in              i_ray = '0;
    logic                 o_busy;
    logic                 o_done;
    t_ray_out             o_hit;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [OBST_W-1:0]    i_cfg_data = '0;

    // shadow copy of the register file
    logic [OBST_W-1:0]    obst_cfg [OBST_NUM];
    logic [COORD_W-1:0]   scr_w = SCREEN_W_RST;
    logic [COORD_W-1:0]   scr_h = SCREEN_H_RST;

    t_ray_in              pending_rays [$];
    t_ray_out             expected_hits [$];
    int                   rays_sent = 0;
    int                   mismatches = 0;
    longint               cycles = 0;
    logic                 beat_taken = 1'b0;

    // sine of 0..90 degrees, q1.14
    int unsigned quarter_sine [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    ray_march_light_hit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_ray      (i_ray),
        .o_busy     (o_busy),
        .o_done     (o_done),
        .o_hit      (o_hit),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // table entry rescaled to the working fraction width
    function automatic longint tab_scaled(int unsigned t);
        int s;
        if (FRAC >= 14) return longint'(t) <<< (FRAC - 14);
        s = 14 - FRAC;
        return (longint'(t) + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // sine by quadrant symmetry, whole degrees
    function automatic longint sine_deg(int unsigned deg);
        int unsigned k;
        k = deg % 360;
        if (k <= 90) return tab_scaled(quarter_sine[k]);
        if (k <= 180) return tab_scaled(quarter_sine[180 - k]);
        if (k <= 270) return -tab_scaled(quarter_sine[k - 180]);
        return -tab_scaled(quarter_sine[360 - k]);
    endfunction

    function automatic bit in_rect(longint px, longint py, longint rx, longint ry,
                                   longint rw, longint rh);
        longint one;
        one = longint'(1) <<< FRAC;
        return px >= rx * one && px < (rx + rw) * one &&
               py >= ry * one && py < (ry + rh) * one;
    endfunction

    // any enabled obstacle or border band holds the point
    function automatic bit point_blocked(longint px, longint py);
        longint w, h, b;
        w = longint'(scr_w);
        h = longint'(scr_h);
        b = BAND;
        for (int k = 0; k < RECT_NUM && k < OBST_NUM; k++) begin
            if (obst_cfg[k][40] &&
                in_rect(px, py, longint'(obst_cfg[k][39:30]), longint'(obst_cfg[k][29:20]),
                        longint'(obst_cfg[k][19:10]), longint'(obst_cfg[k][9:0])))
                return 1'b1;
        end
        if (in_rect(px, py, 0, 0, w, b)) return 1'b1;
        if (in_rect(px, py, 0, h - b, w, b)) return 1'b1;
        if (in_rect(px, py, 0, b, b, h - 2 * b)) return 1'b1;
        if (in_rect(px, py, w - b, b, b, h - 2 * b)) return 1'b1;
        return 1'b0;
    endfunction

    // fixed point to clamped 1/64 pixel units
    function automatic logic [OUT_W-1:0] to_sub_px(longint v);
        longint u;
        if (v < 0) return '0;
        u = v >>> (FRAC - 6);
        return (u > 65535) ? 16'hffff : u[OUT_W-1:0];
    endfunction

    // expected result of one ray
    function automatic t_ray_out march_ray(t_ray_in r);
        t_ray_out    res;
        longint      one, lx, ly, dx, dy, px, py;
        int unsigned a;
        int          steps;
        bit          hit;
        one = longint'(1) <<< FRAC;
        lx = longint'(r.light_x) * one;
        ly = longint'(r.light_y) * one;
        a = int'(r.ray_angle) % DEG_WRAP;
        dx = sine_deg(a);
        dy = -sine_deg(a + 90);
        hit = 1'b0;
        steps = MARCH_MAX;
        px = 0;
        py = 0;
        for (int d = 1; d <= MARCH_MAX && !hit; d++) begin
            px = lx + dx * d;
            py = ly + dy * d;
            if (point_blocked(px, py)) begin
                hit = 1'b1;
                steps = d - 1;
            end
        end
        if (!hit) begin
            px = lx + dx * (MARCH_MAX + 1);
            py = ly + dy * (MARCH_MAX + 1);
        end
        res.hit_x = to_sub_px(px);
        res.hit_y = to_sub_px(py);
        res.blocked = hit;
        res.step_count = steps[STEP_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    function automatic logic [OBST_W-1:0] pack_rect(bit en, int x, int y, int w, int h);
        return {en, x[9:0], y[9:0], w[9:0], h[9:0]};
    endfunction

    // register write beat, enable left high for back-to-back writes
    task automatic write_reg(t_cfg_idx idx, logic [OBST_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == CFG_SCREEN_W) scr_w = val[COORD_W-1:0];
        else if (idx == CFG_SCREEN_H) scr_h = val[COORD_W-1:0];
        else obst_cfg[idx] = val;
    endtask

    task automatic close_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // block idle: nothing queued, nothing outstanding
    task automatic settle();
        while (pending_rays.size() != 0 || expected_hits.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic add_ray(int x, int y, int a);
        t_ray_in r;
        r.light_x = x[COORD_W-1:0];
        r.light_y = y[COORD_W-1:0];
        r.ray_angle = a[ANGLE_W-1:0];
        pending_rays.push_back(r);
    endtask

    // screen size value with junk in the unused upper bits
    function automatic logic [OBST_W-1:0] screen_word(int v);
        logic [OBST_W-1:0] w;
        w = OBST_W'({$urandom(), $urandom()});
        w[COORD_W-1:0] = v[COORD_W-1:0];
        return w;
    endfunction

    task automatic random_config();
        int sel, v;
        for (int k = 0; k < 2; k++) begin
            sel = $urandom_range(9);
            if (sel == 0) v = $urandom_range(20);
            else if (sel == 1) v = 1023;
            else if (sel == 2) v = 16;
            else v = $urandom_range(1023, 200);
            write_reg(k == 0 ? CFG_SCREEN_W : CFG_SCREEN_H, screen_word(v));
        end
        for (int k = 0; k < OBST_NUM; k++) begin
            sel = $urandom_range(9);
            if (sel == 0)
                write_reg(t_cfg_idx'(k), OBST_W'({$urandom(), $urandom()}));
            else if (sel == 1)
                write_reg(t_cfg_idx'(k), '0);
            else
                write_reg(t_cfg_idx'(k),
                          pack_rect(1'b1, $urandom_range(int'(scr_w)),
                                    $urandom_range(int'(scr_h)),
                                    $urandom_range(200), $urandom_range(200)));
        end
        close_writes();
    endtask

    // accept side: log the beat and predict its result
    always @(posedge i_clk) begin
        beat_taken = i_rst_n && i_start && !o_busy;
        if (beat_taken) begin
            expected_hits.push_back(march_ray(i_ray));
            pending_rays.delete(0);
            rays_sent++;
        end
    end

    // drive side: hold until taken, otherwise next ray or idle with junk
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !beat_taken) begin
            i_start <= 1'b1;
        end else if (pending_rays.size() != 0 &&
                     ((rays_sent >= 300 && rays_sent < 420) || $urandom_range(99) >= 12)) begin
            i_start <= 1'b1;
            i_ray <= pending_rays[0];
        end else begin
            i_start <= 1'b0;
            i_ray <= t_ray_in'($urandom());
        end
    end

    // result check against the oldest prediction
    always @(posedge i_clk) begin
        t_ray_out want;
        if (i_rst_n && o_done) begin
            if (expected_hits.size() == 0) begin
                flag_mismatch("result beat with nothing expected");
            end else begin
                want = expected_hits.pop_front();
                if (o_hit.hit_x !== want.hit_x)
                    flag_mismatch($sformatf("hit_x got %0d want %0d", o_hit.hit_x, want.hit_x));
                if (o_hit.hit_y !== want.hit_y)
                    flag_mismatch($sformatf("hit_y got %0d want %0d", o_hit.hit_y, want.hit_y));
                if (o_hit.blocked !== want.blocked)
                    flag_mismatch($sformatf("blocked got %0b want %0b",
                                            o_hit.blocked, want.blocked));
                if (o_hit.step_count !== want.step_count)
                    flag_mismatch($sformatf("step_count got %0d want %0d",
                                            o_hit.step_count, want.step_count));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ray_march_light_hit_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int sel;
        for (int k = 0; k < OBST_NUM; k++) obst_cfg[k] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // reset settings: border hits, first point blocked, step limit, clamping
        add_ray(425, 225, 0);
        add_ray(425, 225, 90);
        add_ray(425, 225, 180);
        add_ray(425, 225, 270);
        add_ray(2, 2, 90);
        add_ray(0, 0, 0);
        add_ray(1023, 300, 90);
        add_ray(300, 1023, 180);
        settle();

        // extreme rectangles, empty and disabled ones, largest screen
        write_reg(CFG_OBST_A, pack_rect(1'b1, 1023, 1023, 1023, 1023));
        write_reg(CFG_OBST_B, pack_rect(1'b1, 100, 100, 0, 50));
        write_reg(CFG_OBST_C, pack_rect(1'b0, 400, 200, 50, 50));
        write_reg(CFG_OBST_D, pack_rect(1'b1, 400, 200, 10, 10));
        write_reg(CFG_OBST_E, pack_rect(1'b1, 0, 0, 1, 1));
        write_reg(CFG_OBST_F, pack_rect(1'b1, 600, 100, 50, 0));
        write_reg(CFG_SCREEN_W, screen_word(1023));
        write_reg(CFG_SCREEN_H, screen_word(1023));
        close_writes();
        add_ray(405, 205, 45);
        add_ray(405, 260, 0);
        add_ray(1000, 1000, 135);
        add_ray(105, 120, 0);
        add_ray(420, 230, 360);
        add_ray(610, 150, 0);
        settle();

        // screen below the usual minimum: bands empty or negative
        for (int k = 0; k < OBST_NUM; k++) write_reg(t_cfg_idx'(k), '0);
        write_reg(CFG_SCREEN_W, screen_word(0));
        write_reg(CFG_SCREEN_H, screen_word(9));
        close_writes();
        add_ray(0, 0, 90);
        add_ray(5, 5, 135);
        add_ray(0, 8, 511);
        settle();

        // smallest regular screen, angles past the wrap
        write_reg(CFG_SCREEN_W, screen_word(16));
        write_reg(CFG_SCREEN_H, screen_word(16));
        close_writes();
        add_ray(8, 8, 0);
        add_ray(8, 8, 359);
        add_ray(7, 7, 225);
        add_ray(10, 10, 400);

        // random phases: mostly lights on screen, some anywhere
        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            random_config();
            for (int i = 0; i < RAYS_PER_PHASE; i++) begin
                sel = $urandom_range(9);
                if (sel < 8)
                    add_ray($urandom_range(int'(scr_w)), $urandom_range(int'(scr_h)),
                            $urandom_range(359));
                else
                    add_ray($urandom_range(1023), $urandom_range(1023), $urandom_range(511));
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ray_march_light_hit_tb: PASS");
        end else begin
            $display("ray_march_light_hit_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rmlh_pkg.sv
rtl/ray_march_light_hit.sv
tb/ray_march_light_hit_tb.sv
